// ----- rtl/core/lbs_pkg.sv -----
package lbs_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned SosSteps        = 19;

  localparam int unsigned DelayBits = 11;
  localparam int unsigned CountBits = 17;
  localparam int unsigned StepBits  = 5;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned IndexBits = 1;

  localparam logic [DelayBits-1:0] DelayFast  = 11'd200;
  localparam logic [DelayBits-1:0] DelayNorm  = 11'd1000;
  localparam logic [DelayBits-1:0] DelaySlow  = 11'd2000;
  localparam logic [DelayBits-1:0] DelayDot   = 11'd200;
  localparam logic [DelayBits-1:0] DelayDash  = 11'd600;
  localparam logic [DelayBits-1:0] DelayPause = 11'd1400;

  // dash steps are 6..11 of the pattern
  localparam logic [StepBits-1:0] DashFirst = 5'd6;
  localparam logic [StepBits-1:0] DashEnd   = 5'd12;
  localparam logic [StepBits-1:0] LastStep  = StepBits'(SosSteps - 1);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FAST   = 2'd1,
    MODE_SLOW   = 2'd2,
    MODE_SOS    = 2'd3
  } lbs_mode_t;

  typedef enum logic [IndexBits-1:0] {
    REG_SPEED_MODE   = 1'd0,
    REG_BLINK_TARGET = 1'd1
  } lbs_reg_t;

  typedef struct packed {
    logic                 lit;
    logic                 running;
    logic [CountBits-1:0] toggle_count;
    logic [DelayBits-1:0] active_delay;
    logic [StepBits-1:0]  step;
  } lbs_state_t;

  function automatic logic [DelayBits-1:0] mode_delay(input lbs_mode_t mode);
    logic [DelayBits-1:0] d;
    unique case (mode)
      MODE_FAST: d = DelayFast;
      MODE_SLOW: d = DelaySlow;
      MODE_SOS:  d = DelayDot;
      default:   d = DelayNorm;
    endcase
    return d;
  endfunction

  function automatic lbs_state_t restart_state(input lbs_mode_t mode);
    lbs_state_t s;
    s.lit          = 1'b0;
    s.running      = 1'b1;
    s.toggle_count = '0;
    s.active_delay = mode_delay(mode);
    s.step         = '0;
    return s;
  endfunction

endpackage

// ----- rtl/core/led_blink_and_sos_sequencer.sv -----
// led blink and sos sequencer: one time sample in, one led/done result out
// registered path: input register, then result register, from input accept to result valid
// throughput: one item per cycle while out_stall is low; the elapsed subtract/compare sets the path
// reset (rst, synchronous, active high): speed mode 0, blink target 0, lit state off,
// sequence running, last change time 0, delay 1000 ms; both stages empty
// any register write restarts the sequence with the new settings
module led_blink_and_sos_sequencer #(
  parameter int unsigned TIME_BITS = lbs_pkg::TimeBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_wen,
  input  logic [lbs_pkg::IndexBits-1:0] cfg_index,
  input  logic [lbs_pkg::CfgBits-1:0]   cfg_data,
  // time sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [TIME_BITS-1:0]          now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          led_on,
  output logic                          sequence_done
);
  import lbs_pkg::*;

  // configuration registers
  lbs_mode_t           speed_mode;
  logic [CfgBits-1:0]  blink_target;

  // sequencer state
  lbs_state_t           state;
  lbs_state_t           state_next;
  logic [TIME_BITS-1:0] last_change;
  logic [TIME_BITS-1:0] last_change_next;

  // input register
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_now;

  logic advance;
  logic led_next;
  logic done_next;

  // the held item moves on when the result register is empty or being drained
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  lbs_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .state            (state),
    .last_change      (last_change),
    .now_ms           (s1_now),
    .speed_mode       (speed_mode),
    .blink_target     (blink_target),
    .state_next       (state_next),
    .last_change_next (last_change_next),
    .led_on           (led_next),
    .sequence_done    (done_next)
  );

  // config registers and sequencer state; a write restarts with the new settings
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode   <= MODE_NORMAL;
      blink_target <= '0;
      state        <= restart_state(MODE_NORMAL);
      last_change  <= '0;
    end else if (cfg_wen) begin
      last_change <= '0;
      unique case (lbs_reg_t'(cfg_index))
        REG_SPEED_MODE: begin
          speed_mode <= lbs_mode_t'(cfg_data[1:0]);
          state      <= restart_state(lbs_mode_t'(cfg_data[1:0]));
        end
        REG_BLINK_TARGET: begin
          blink_target <= cfg_data;
          state        <= restart_state(speed_mode);
        end
        default: begin
          state <= state;
        end
      endcase
    end else if (advance) begin
      state       <= state_next;
      last_change <= last_change_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_now <= now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_on        <= led_next;
      sequence_done <= done_next;
    end
  end

endmodule

// ----- rtl/core/lbs_step.sv -----
module lbs_step #(
  parameter int unsigned TIME_BITS = lbs_pkg::TimeBitsDefault
) (
  input  lbs_pkg::lbs_state_t                 state,
  input  logic [TIME_BITS-1:0]                last_change,
  input  logic [TIME_BITS-1:0]                now_ms,
  input  lbs_pkg::lbs_mode_t                  speed_mode,
  input  logic [lbs_pkg::CfgBits-1:0]         blink_target,
  output lbs_pkg::lbs_state_t                 state_next,
  output logic [TIME_BITS-1:0]                last_change_next,
  output logic                                led_on,
  output logic                                sequence_done
);
  import lbs_pkg::*;

  logic [TIME_BITS-1:0] elapsed;
  logic                 due;
  logic                 finished;

  // wrap-around elapsed time against the current delay
  assign elapsed  = now_ms - last_change;
  assign due      = elapsed >= {{(TIME_BITS-DelayBits){1'b0}}, state.active_delay};
  assign finished = (blink_target != '0) &&
                    (state.toggle_count >= {blink_target, 1'b0});

  always_comb begin
    state_next       = state;
    last_change_next = last_change;
    if (speed_mode == MODE_SOS) begin
      if (due) begin
        last_change_next = now_ms;
        if (state.step >= LastStep) begin
          state_next.lit          = 1'b0;
          state_next.active_delay = DelayPause;
          state_next.step         = '0;
        end else begin
          state_next.step = state.step + 1'b1;
          if (!state.step[0]) begin
            state_next.lit          = 1'b1;
            state_next.active_delay = (state.step >= DashFirst && state.step < DashEnd)
                                      ? DelayDash : DelayDot;
          end else begin
            state_next.lit          = 1'b0;
            state_next.active_delay = DelayDot;
          end
        end
      end
    end else begin
      priority if (finished) begin
        state_next.lit     = 1'b0;
        state_next.running = 1'b0;
      end else if (due) begin
        state_next.lit          = !state.lit;
        state_next.toggle_count = state.toggle_count + 1'b1;
        last_change_next        = now_ms;
      end
    end
  end

  assign led_on        = state_next.lit;
  assign sequence_done = (speed_mode != MODE_SOS) && !state_next.running;

endmodule
